// ----- hw/rtl/bilinear_image_scaler_core_assert.svh -----
// Assertion macros shared by the scaler checkers.
// Both macros sample on the rising edge of clk_i of the enclosing scope.
`ifndef BILINEAR_IMAGE_SCALER_CORE_ASSERT_SVH
`define BILINEAR_IMAGE_SCALER_CORE_ASSERT_SVH

// Checked only while out of reset.
`define BIS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Checked at every edge, also while reset is held.
`define BIS_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// ----- hw/rtl/bis_pkg.sv -----
package bis_pkg;

  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 24;
  localparam int unsigned SIZE_W     = 9;
  localparam int unsigned SCALE_W    = 24;
  localparam int unsigned COORD_W    = 12;
  // Q20.16 source position: 12-bit coordinate times Q8.16 scale
  localparam int unsigned POS_W      = COORD_W + SCALE_W;
  localparam int unsigned OUT_PLANES = 3;

  localparam logic [SIZE_W-1:0]  RESET_SIZE      = 9'd256;
  localparam logic [SCALE_W-1:0] RESET_INV_SCALE = 24'd65536;  // 1.0 in Q8.16
  localparam logic [8:0]         WEIGHT_ONE      = 9'd256;     // 1.0 in Q1.8

  localparam logic CMD_WRITE   = 1'b0;
  localparam logic CMD_REQUEST = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SOURCE_WIDTH  = 2'd0,
    CFG_SOURCE_HEIGHT = 2'd1,
    CFG_INV_XSCALE    = 2'd2,
    CFG_INV_YSCALE    = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    logic               command;
    logic [COORD_W-1:0] column;
    logic [COORD_W-1:0] row;
    logic [7:0]         red_in;
    logic [7:0]         green_in;
    logic [7:0]         blue_in;
  } in_item_t;

  typedef struct packed {
    logic [7:0] red_out;
    logic [7:0] green_out;
    logic [7:0] blue_out;
  } out_item_t;

endpackage

// ----- hw/rtl/bis_stream_if.sv -----
interface bis_stream_if #(
  parameter type T = logic
) ();
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ----- hw/rtl/bis_ram.sv -----
module bis_ram #(
  parameter int WIDTH  = 24,
  parameter int DEPTH  = 16384,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [WIDTH-1:0]  wdata_i,
  input  logic              re_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- hw/rtl/bis_locate.sv -----
module bis_locate
  import bis_pkg::*;
#(
  parameter int IDX_W    = 8,
  parameter int MAX_SIZE = 256
) (
  input  logic [POS_W-1:0]  pos_i,
  input  logic [SIZE_W-1:0] size_i,
  output logic [IDX_W-1:0]  lo_o,
  output logic [IDX_W-1:0]  hi_o,
  output logic [7:0]        frac_o
);

  localparam int SZ_W = 13;
  localparam int IP_W = POS_W - 16;
  localparam logic [SZ_W-1:0] MaxSize = SZ_W'(MAX_SIZE);

  logic [SZ_W-1:0]  size_ext;
  logic [SZ_W-1:0]  size_eff;
  logic [SZ_W-1:0]  last_ext;
  logic [IDX_W-1:0] last_idx;
  logic [IP_W-1:0]  ip;
  logic             over;

  always_comb begin
    size_ext = SZ_W'(size_i);
    // zero acts as one, oversize acts as the store size
    if (size_ext == '0) begin
      size_eff = SZ_W'(1);
    end else if (size_ext > MaxSize) begin
      size_eff = MaxSize;
    end else begin
      size_eff = size_ext;
    end
    last_ext = size_eff - SZ_W'(1);
    last_idx = last_ext[IDX_W-1:0];

    ip   = pos_i[POS_W-1:16];
    over = ip > IP_W'(last_ext);

    // past the edge: clamp and drop the weight
    lo_o   = over ? last_idx : ip[IDX_W-1:0];
    hi_o   = (lo_o == last_idx) ? lo_o : lo_o + 1'b1;
    frac_o = over ? 8'd0 : pos_i[15:8];
  end

endmodule

// ----- hw/rtl/bilinear_image_scaler_core.sv -----
// Bilinear image scaler core.
// in_i carries commands: a write beat stores one RGB source pixel at
// (column, row); a request beat names a destination pixel, which is mapped
// through the Q8.16 inverse scale registers onto the source frame and
// blended from its four neighbours. Each request gives one beat on out_o;
// writes give none. Registers are set through cfg_we_i / cfg_index_i /
// cfg_data_i, by the user only while no request is in flight; the block
// does not enforce this. Throughput: one beat per cycle on in_i unless
// out_o stalls, writes and requests mixed freely. A request passes six
// register stages (multiply, locate, store read, weights, products, sum)
// on its way to out_o. The store is four banks split by row and column
// parity, so all four neighbours are read in the same cycle.
// Reset clears the pipeline valids and loads the registers with a full
// 256 x 256 frame at scale 1.0; the frame store itself is not cleared.
// While out_o is held valid and not ready, the whole pipeline holds and
// in_i.ready drops; nothing is lost or repeated.
module bilinear_image_scaler_core
  import bis_pkg::*;
#(
  parameter int MAX_WIDTH  = 256,
  parameter int MAX_HEIGHT = 256,
  parameter int PLANES     = 3
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  bis_stream_if.sink            in_i,
  bis_stream_if.source          out_o
);

  localparam int XW        = $clog2(MAX_WIDTH);
  localparam int YW        = $clog2(MAX_HEIGHT);
  localparam int SP        = (PLANES < OUT_PLANES) ? PLANES : OUT_PLANES;
  localparam int PIX_W     = SP * 8;
  localparam int HalfW     = (MAX_WIDTH + 1) / 2;
  localparam int HalfH     = (MAX_HEIGHT + 1) / 2;
  localparam int BankDepth = HalfW * HalfH;
  localparam int BankAw    = (BankDepth > 1) ? $clog2(BankDepth) : 1;
  localparam int W_W       = 17;  // corner weight, up to 1.0 in Q1.16
  localparam int PROD_W    = W_W + 8;
  localparam int SUM_W     = PROD_W + 1;

  function automatic logic [BankAw-1:0] bank_addr(logic [XW-1:0] x, logic [YW-1:0] y);
    return BankAw'(y >> 1) * BankAw'(HalfW) + BankAw'(x >> 1);
  endfunction

  // Configuration registers
  logic [SIZE_W-1:0]  src_width_q, src_height_q;
  logic [SCALE_W-1:0] inv_x_q, inv_y_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src_width_q  <= RESET_SIZE;
      src_height_q <= RESET_SIZE;
      inv_x_q      <= RESET_INV_SCALE;
      inv_y_q      <= RESET_INV_SCALE;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_SOURCE_WIDTH:  src_width_q  <= cfg_data_i[SIZE_W-1:0];
        CFG_SOURCE_HEIGHT: src_height_q <= cfg_data_i[SIZE_W-1:0];
        CFG_INV_XSCALE:    inv_x_q      <= cfg_data_i[SCALE_W-1:0];
        CFG_INV_YSCALE:    inv_y_q      <= cfg_data_i[SCALE_W-1:0];
      endcase
    end
  end

  // Global advance: every stage moves unless the output beat is stuck
  logic out_valid_q;
  logic adv;

  assign adv        = !out_valid_q || out_o.ready;
  assign in_i.ready = adv;

  // Stage 1: scale multiply
  logic [7:0]         in_planes [OUT_PLANES];
  logic [PIX_W-1:0]   pix_d;
  logic [POS_W-1:0]   pos_x_d, pos_y_d;

  always_comb begin
    in_planes[0] = in_i.data.red_in;
    in_planes[1] = in_i.data.green_in;
    in_planes[2] = in_i.data.blue_in;
    for (int p = 0; p < SP; p++) begin
      pix_d[8*p +: 8] = in_planes[p];
    end
  end

  assign pos_x_d = POS_W'(in_i.data.column) * POS_W'(inv_x_q);
  assign pos_y_d = POS_W'(in_i.data.row) * POS_W'(inv_y_q);

  logic               s1_valid_q;
  logic               s1_cmd_q;
  logic [COORD_W-1:0] s1_col_q, s1_row_q;
  logic [PIX_W-1:0]   s1_pix_q;
  logic [POS_W-1:0]   s1_pos_x_q, s1_pos_y_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_cmd_q   <= in_i.data.command;
      s1_col_q   <= in_i.data.column;
      s1_row_q   <= in_i.data.row;
      s1_pix_q   <= pix_d;
      s1_pos_x_q <= pos_x_d;
      s1_pos_y_q <= pos_y_d;
    end
  end

  // Stage 2: integer position, clamp, weights
  logic [XW-1:0] x0_d, x1_d;
  logic [YW-1:0] y0_d, y1_d;
  logic [7:0]    a_d, b_d;
  logic          wr_ok_d;

  bis_locate #(
    .IDX_W    (XW),
    .MAX_SIZE (MAX_WIDTH)
  ) u_loc_x (
    .pos_i  (s1_pos_x_q),
    .size_i (src_width_q),
    .lo_o   (x0_d),
    .hi_o   (x1_d),
    .frac_o (a_d)
  );

  bis_locate #(
    .IDX_W    (YW),
    .MAX_SIZE (MAX_HEIGHT)
  ) u_loc_y (
    .pos_i  (s1_pos_y_q),
    .size_i (src_height_q),
    .lo_o   (y0_d),
    .hi_o   (y1_d),
    .frac_o (b_d)
  );

  // drop writes outside the store
  assign wr_ok_d = (13'(s1_col_q) < 13'(MAX_WIDTH)) && (13'(s1_row_q) < 13'(MAX_HEIGHT));

  logic             s2_valid_q;
  logic             s2_cmd_q;
  logic             s2_wr_ok_q;
  logic [XW-1:0]    s2_wcol_q, s2_x0_q, s2_x1_q;
  logic [YW-1:0]    s2_wrow_q, s2_y0_q, s2_y1_q;
  logic [PIX_W-1:0] s2_pix_q;
  logic [7:0]       s2_a_q, s2_b_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s2_cmd_q   <= s1_cmd_q;
      s2_wr_ok_q <= wr_ok_d;
      s2_wcol_q  <= s1_col_q[XW-1:0];
      s2_wrow_q  <= s1_row_q[YW-1:0];
      s2_pix_q   <= s1_pix_q;
      s2_x0_q    <= x0_d;
      s2_x1_q    <= x1_d;
      s2_y0_q    <= y0_d;
      s2_y1_q    <= y1_d;
      s2_a_q     <= a_d;
      s2_b_q     <= b_d;
    end
  end

  // Store access: four parity banks, writes and reads at the same stage
  logic [PIX_W-1:0] bank_rdata [4];

  for (genvar bk = 0; bk < 4; bk++) begin : g_bank
    localparam logic [1:0] Bank = 2'(bk);

    logic [XW-1:0]     rd_x;
    logic [YW-1:0]     rd_y;
    logic [BankAw-1:0] raddr, waddr;
    logic              we;

    // pick the neighbour whose parity lands in this bank
    assign rd_x  = (s2_x0_q[0] == Bank[0]) ? s2_x0_q : s2_x1_q;
    assign rd_y  = (s2_y0_q[0] == Bank[1]) ? s2_y0_q : s2_y1_q;
    assign raddr = bank_addr(rd_x, rd_y);
    assign waddr = bank_addr(s2_wcol_q, s2_wrow_q);
    assign we    = adv && s2_valid_q && (s2_cmd_q == CMD_WRITE) && s2_wr_ok_q
                   && (s2_wcol_q[0] == Bank[0]) && (s2_wrow_q[0] == Bank[1]);

    bis_ram #(
      .WIDTH (PIX_W),
      .DEPTH (BankDepth)
    ) u_bank (
      .clk_i   (clk_i),
      .we_i    (we),
      .waddr_i (waddr),
      .wdata_i (s2_pix_q),
      .re_i    (adv),
      .raddr_i (raddr),
      .rdata_o (bank_rdata[bk])
    );
  end

  // Stage 3: read data arrives alongside these
  logic       s3_valid_q;
  logic       s3_x0p_q, s3_x1p_q, s3_y0p_q, s3_y1p_q;
  logic [7:0] s3_a_q, s3_b_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s3_x0p_q <= s2_x0_q[0];
      s3_x1p_q <= s2_x1_q[0];
      s3_y0p_q <= s2_y0_q[0];
      s3_y1p_q <= s2_y1_q[0];
      s3_a_q   <= s2_a_q;
      s3_b_q   <= s2_b_q;
    end
  end

  // Corner order: 00, 10, 01, 11 (x then y)
  logic [8:0]       na_d, nb_d;
  logic [W_W-1:0]   w_d [4];
  logic [PIX_W-1:0] q_d [4];

  always_comb begin
    na_d   = WEIGHT_ONE - {1'b0, s3_a_q};
    nb_d   = WEIGHT_ONE - {1'b0, s3_b_q};
    w_d[0] = W_W'(na_d) * W_W'(nb_d);
    w_d[1] = W_W'({1'b0, s3_a_q}) * W_W'(nb_d);
    w_d[2] = W_W'(na_d) * W_W'({1'b0, s3_b_q});
    w_d[3] = W_W'({1'b0, s3_a_q}) * W_W'({1'b0, s3_b_q});
    q_d[0] = bank_rdata[{s3_y0p_q, s3_x0p_q}];
    q_d[1] = bank_rdata[{s3_y0p_q, s3_x1p_q}];
    q_d[2] = bank_rdata[{s3_y1p_q, s3_x0p_q}];
    q_d[3] = bank_rdata[{s3_y1p_q, s3_x1p_q}];
  end

  // Stage 4: weights and neighbours
  logic             s4_valid_q;
  logic [W_W-1:0]   s4_w_q [4];
  logic [PIX_W-1:0] s4_q_q [4];

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s4_w_q <= w_d;
      s4_q_q <= q_d;
    end
  end

  // Stage 5: per-plane products
  logic              s5_valid_q;
  logic [PROD_W-1:0] prod_d [SP][4];
  logic [PROD_W-1:0] s5_prod_q [SP][4];

  always_comb begin
    for (int p = 0; p < SP; p++) begin
      for (int k = 0; k < 4; k++) begin
        prod_d[p][k] = PROD_W'(s4_w_q[k]) * PROD_W'(s4_q_q[k][8*p +: 8]);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s5_prod_q <= prod_d;
    end
  end

  // Output stage: sum and truncate to 8 bits
  logic [SUM_W-1:0] sum_d [SP];
  logic [7:0]       out_planes [OUT_PLANES];
  out_item_t        out_data_d, out_data_q;

  always_comb begin
    for (int p = 0; p < SP; p++) begin
      sum_d[p] = SUM_W'(s5_prod_q[p][0]) + SUM_W'(s5_prod_q[p][1])
               + SUM_W'(s5_prod_q[p][2]) + SUM_W'(s5_prod_q[p][3]);
    end
    for (int p = 0; p < OUT_PLANES; p++) begin
      out_planes[p] = '0;
    end
    for (int p = 0; p < SP; p++) begin
      out_planes[p] = sum_d[p][23:16];
    end
    out_data_d.red_out   = out_planes[0];
    out_data_d.green_out = out_planes[1];
    out_data_d.blue_out  = out_planes[2];
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_data_q <= out_data_d;
    end
  end

  // Valid bits: writes leave the pipe after the store stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      s3_valid_q  <= 1'b0;
      s4_valid_q  <= 1'b0;
      s5_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (adv) begin
      s1_valid_q  <= in_i.valid;
      s2_valid_q  <= s1_valid_q;
      s3_valid_q  <= s2_valid_q && (s2_cmd_q == CMD_REQUEST);
      s4_valid_q  <= s3_valid_q;
      s5_valid_q  <= s4_valid_q;
      out_valid_q <= s5_valid_q;
    end
  end

  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_data_q;

endmodule

// ----- hw/rtl/bis_checker.sv -----
`include "bilinear_image_scaler_core_assert.svh"

module bis_checker
  import bis_pkg::*;
(
  input logic      clk_i,
  input logic      rst_ni,
  input logic      in_ready_i,
  input logic      out_valid_i,
  input logic      out_ready_i,
  input out_item_t out_data_i
);

  // a stalled result beat holds
  property p_out_hold;
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_data_i);
  endproperty

  // input stalls only when a result beat is stuck
  property p_in_ready;
    in_ready_i == (!out_valid_i || out_ready_i);
  endproperty

  property p_reset_idle;
    !rst_ni |-> !out_valid_i;
  endproperty

  `BIS_ASSERT(a_out_hold, p_out_hold, "result beat changed while stalled")
  `BIS_ASSERT(a_in_ready, p_in_ready, "input ready does not follow output stall")
  `BIS_ASSERT_RST(a_reset_idle, p_reset_idle, "result beat shown during reset")

endmodule

bind bilinear_image_scaler_core bis_checker u_bis_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_data_i  (out_o.data)
);

// ----- verif/bilinear_image_scaler_core_tb.sv -----
`timescale 1ns / 1ps

module bilinear_image_scaler_core_tb;
  import bis_pkg::*;

  localparam int unsigned FRAME_W      = 256;
  localparam int unsigned FRAME_H      = 256;
  localparam int unsigned PLANE_CNT    = 3;
  localparam int unsigned SETTLE_SLACK = 16;
  localparam int unsigned ITEM_TARGET  = 1950;

  typedef logic [2:0][7:0] rgb_t;  // [0] red, [1] green, [2] blue

  typedef struct {
    in_item_t    beat;
    bit          typed;
    logic [23:0] want;
  } scaler_vector_t;

  typedef enum logic [1:0] {
    SINK_OPEN,
    SINK_BUSY_LIGHT,
    SINK_BUSY_HEAVY,
    SINK_PERIODIC
  } sink_mode_e;

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  cfg_we_i;
  cfg_idx_e              cfg_index_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  bis_stream_if #(.T(in_item_t))  pix_in ();
  bis_stream_if #(.T(out_item_t)) pix_out ();

  bilinear_image_scaler_core #(
    .MAX_WIDTH (FRAME_W),
    .MAX_HEIGHT(FRAME_H),
    .PLANES    (PLANE_CNT)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i),
    .in_i       (pix_in),
    .out_o      (pix_out)
  );

  always #1 clk_i = ~clk_i;

  // Scaler model state, updated on accepted beats and register writes
  rgb_t               frame_model [FRAME_H][FRAME_W];
  logic [SIZE_W-1:0]  model_width;
  logic [SIZE_W-1:0]  model_height;
  logic [SCALE_W-1:0] model_xinv;
  logic [SCALE_W-1:0] model_yinv;
  out_item_t          scaled_pixel_q [$];
  logic [24:0]        typed_pixel_q [$];  // {typed, value} per directed request
  int unsigned        err_cnt = 0;
  string              plane_name [3] = '{"red_out", "green_out", "blue_out"};

  // Stimulus side: which store entries are written, and the active setting
  bit                 pix_loaded [FRAME_H][FRAME_W];
  int unsigned        gen_w = FRAME_W;
  int unsigned        gen_h = FRAME_H;
  logic [SCALE_W-1:0] gen_xinv = RESET_INV_SCALE;
  logic [SCALE_W-1:0] gen_yinv = RESET_INV_SCALE;
  int unsigned        burst_left = 0;
  int unsigned        items_sent = 0;

  sink_mode_e         sink_mode = SINK_OPEN;
  int unsigned        sink_left = 0;

  function automatic int unsigned eff_size(input logic [SIZE_W-1:0] raw,
                                           input int unsigned max_size);
    if (raw == 0) return 1;
    return (raw > max_size) ? max_size : raw;
  endfunction

  // Destination coordinate -> integer source index, next index, Q0.8 weight
  function automatic void map_axis(input logic [COORD_W-1:0] coord,
                                   input logic [SCALE_W-1:0] inv,
                                   input int unsigned span,
                                   output int unsigned lo, output int unsigned hi,
                                   output int unsigned wt);
    logic [POS_W-1:0] pos;
    int unsigned      edge_idx;
    pos      = POS_W'(coord) * POS_W'(inv);
    edge_idx = span - 1;
    lo       = pos[POS_W-1:16];
    wt       = pos[15:8];
    if (lo > edge_idx) begin
      lo = edge_idx;
      wt = 0;
    end
    hi = (lo >= edge_idx) ? lo : lo + 1;
  endfunction

  function automatic scaler_vector_t pixel_vec(input logic cmd, input int unsigned col,
                                               input int unsigned row, input logic [23:0] rgb,
                                               input bit typed = 1'b0,
                                               input logic [23:0] want = '0);
    scaler_vector_t v;
    v.beat.command  = cmd;
    v.beat.column   = COORD_W'(col);
    v.beat.row      = COORD_W'(row);
    v.beat.red_in   = rgb[23:16];
    v.beat.green_in = rgb[15:8];
    v.beat.blue_in  = rgb[7:0];
    v.typed         = typed;
    v.want          = want;
    return v;
  endfunction

  // Pick a destination coordinate, mostly one that lands inside the source
  function automatic logic [COORD_W-1:0] pick_coord(input int unsigned span,
                                                    input logic [SCALE_W-1:0] inv);
    int unsigned      target;
    logic [POS_W-1:0] num;
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      2, 3: return COORD_W'($urandom_range(0, 4095));
      4: return COORD_W'($urandom_range(0, span + 3));
      default: begin
        if (inv == 0) return COORD_W'($urandom_range(0, 4095));
        target = $urandom_range(0, span);
        num    = (POS_W'(target) << 16) + POS_W'($urandom_range(0, 65535));
        num    = num / POS_W'(inv);
        return (num > 4095) ? '1 : num[COORD_W-1:0];
      end
    endcase
  endfunction

  function automatic logic [SIZE_W-1:0] pick_size();
    case ($urandom_range(0, 9))
      0, 1: return SIZE_W'($urandom_range(1, 4));
      2, 3, 4: return SIZE_W'($urandom_range(5, 16));
      5: return SIZE_W'(256);
      6: return $urandom_range(0, 1) ? '0 : SIZE_W'($urandom_range(257, 511));
      default: return SIZE_W'($urandom_range(17, 255));
    endcase
  endfunction

  function automatic logic [SCALE_W-1:0] pick_inv_scale();
    case ($urandom_range(0, 9))
      0, 1: return RESET_INV_SCALE;
      2, 3, 4: return SCALE_W'($urandom_range(1, 'h1FFFF));
      5, 6: return SCALE_W'($urandom_range(1, 'hFFFF));
      7: return '0;
      8: return '1;
      default: return SCALE_W'($urandom_range(0, 'hFFFFFF));
    endcase
  endfunction

  task automatic write_reg(input cfg_idx_e idx, input logic [CFG_DATA_W-1:0] val);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(posedge clk_i);
  endtask

  task automatic load_regs(input logic [SIZE_W-1:0] w, input logic [SIZE_W-1:0] h,
                           input logic [SCALE_W-1:0] xinv, input logic [SCALE_W-1:0] yinv);
    write_reg(CFG_SOURCE_WIDTH, CFG_DATA_W'(w));
    write_reg(CFG_SOURCE_HEIGHT, CFG_DATA_W'(h));
    write_reg(CFG_INV_XSCALE, xinv);
    write_reg(CFG_INV_YSCALE, yinv);
    cfg_we_i <= 1'b0;
    gen_w    = eff_size(w, FRAME_W);
    gen_h    = eff_size(h, FRAME_H);
    gen_xinv = xinv;
    gen_yinv = yinv;
  endtask

  // Send one beat in bursts with random gaps; return at the accepting edge
  task automatic push_beat(input in_item_t beat);
    int unsigned gap;
    if (burst_left == 0) begin
      gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                               : $urandom_range(1, 12);
      if (gap != 0) begin
        pix_in.valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    pix_in.valid <= 1'b1;
    pix_in.data  <= beat;
    if (beat.command == CMD_WRITE && beat.column < FRAME_W && beat.row < FRAME_H)
      pix_loaded[beat.row][beat.column] = 1'b1;
    do @(posedge clk_i); while (!pix_in.ready);
  endtask

  // Drop valid, wait for every pending pixel, then let the pipeline empty
  task automatic settle();
    pix_in.valid <= 1'b0;
    while (scaled_pixel_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_SLACK) @(posedge clk_i);
  endtask

  // Output side stalls on a random mode that is drawn anew when its run ends
  always @(posedge clk_i) begin
    if (sink_left == 0) begin
      sink_mode = sink_mode_e'($urandom_range(0, 3));
      sink_left = $urandom_range(20, 200);
    end
    sink_left--;
    case (sink_mode)
      SINK_OPEN:       pix_out.ready <= 1'b1;
      SINK_BUSY_LIGHT: pix_out.ready <= ($urandom_range(0, 3) != 0);
      SINK_BUSY_HEAVY: pix_out.ready <= ($urandom_range(0, 3) == 0);
      default:         pix_out.ready <= ((sink_left % 9) >= 4);
    endcase
  end

  always @(posedge clk_i or negedge rst_ni) begin : scaler_model
    in_item_t    beat;
    out_item_t   want;
    logic [23:0] got_bits;
    logic [23:0] want_bits;
    logic [23:0] blend_bits;
    logic [24:0] typed;
    int unsigned x0, x1, y0, y1, wa, wb, acc;
    if (!rst_ni) begin
      model_width  = RESET_SIZE;
      model_height = RESET_SIZE;
      model_xinv   = RESET_INV_SCALE;
      model_yinv   = RESET_INV_SCALE;
    end else begin
      if (pix_out.valid && pix_out.ready) begin
        if (scaled_pixel_q.size() == 0) begin
          $error("output beat %h with no pixel pending", pix_out.data);
          err_cnt++;
        end else begin
          want      = scaled_pixel_q.pop_front();
          want_bits = want;
          got_bits  = pix_out.data;
          for (int p = 0; p < 3; p++) begin
            if (got_bits[8*(2-p) +: 8] !== want_bits[8*(2-p) +: 8]) begin
              $error("%s: expected %0d, actual %0d", plane_name[p],
                     want_bits[8*(2-p) +: 8], got_bits[8*(2-p) +: 8]);
              err_cnt++;
            end
          end
        end
      end
      if (cfg_we_i) begin
        case (cfg_index_i)
          CFG_SOURCE_WIDTH:  model_width  = cfg_data_i[SIZE_W-1:0];
          CFG_SOURCE_HEIGHT: model_height = cfg_data_i[SIZE_W-1:0];
          CFG_INV_XSCALE:    model_xinv   = cfg_data_i[SCALE_W-1:0];
          CFG_INV_YSCALE:    model_yinv   = cfg_data_i[SCALE_W-1:0];
          default: ;
        endcase
      end
      if (pix_in.valid && pix_in.ready) begin
        beat = pix_in.data;
        if (beat.command == CMD_WRITE) begin
          // writes outside the store are dropped
          if (beat.column < FRAME_W && beat.row < FRAME_H)
            frame_model[beat.row][beat.column] = {beat.blue_in, beat.green_in, beat.red_in};
        end else begin
          map_axis(beat.column, model_xinv, eff_size(model_width, FRAME_W), x0, x1, wa);
          map_axis(beat.row, model_yinv, eff_size(model_height, FRAME_H), y0, y1, wb);
          for (int p = 0; p < 3; p++) begin
            acc = (WEIGHT_ONE - wa) * (WEIGHT_ONE - wb) * frame_model[y0][x0][p]
                + wa * (WEIGHT_ONE - wb) * frame_model[y0][x1][p]
                + (WEIGHT_ONE - wa) * wb * frame_model[y1][x0][p]
                + wa * wb * frame_model[y1][x1][p];
            blend_bits[8*(2-p) +: 8] = acc[23:16];
          end
          if (typed_pixel_q.size() != 0) begin
            typed = typed_pixel_q.pop_front();
            if (typed[24]) blend_bits = typed[23:0];
          end
          scaled_pixel_q.push_back(out_item_t'(blend_bits));
        end
      end
    end
  end

  initial begin
    scaler_vector_t      directed_tbl [];
    in_item_t            beat;
    int unsigned         phase_idx;
    int unsigned         steps;
    int unsigned         roll;
    int unsigned         slot;
    int unsigned         x0, x1, y0, y1, wa, wb;
    int unsigned         nx [4];
    int unsigned         ny [4];
    logic [COORD_W-1:0]  cand_col;
    logic [COORD_W-1:0]  cand_row;
    bit                  pending;

    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_index_i   = CFG_SOURCE_WIDTH;
    cfg_data_i    = '0;
    pix_in.valid  = 1'b0;
    pix_in.data   = '0;
    pix_out.ready = 1'b0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset setting: full 256 x 256 frame at scale 1.0, so requests hit pixels exactly
    directed_tbl = '{
      pixel_vec(CMD_WRITE, 0, 0, 24'hFF00AA),
      pixel_vec(CMD_WRITE, 1, 0, 24'h00FF55),
      pixel_vec(CMD_WRITE, 0, 1, 24'h123456),
      pixel_vec(CMD_WRITE, 1, 1, 24'hFFFFFF),
      pixel_vec(CMD_REQUEST, 0, 0, 24'h5A5A5A, 1'b1, 24'hFF00AA),
      pixel_vec(CMD_WRITE, 255, 255, 24'h807F01),
      pixel_vec(CMD_WRITE, 254, 255, 24'h000000),
      pixel_vec(CMD_WRITE, 255, 254, 24'h010203),
      pixel_vec(CMD_WRITE, 254, 254, 24'hC3A5E1),
      pixel_vec(CMD_REQUEST, 255, 255, 24'hA5A5A5, 1'b1, 24'h807F01),
      pixel_vec(CMD_REQUEST, 4095, 4095, 24'hFFFFFF, 1'b1, 24'h807F01),
      pixel_vec(CMD_REQUEST, 254, 254, 24'h000000, 1'b1, 24'hC3A5E1),
      pixel_vec(CMD_WRITE, 256, 0, 24'hFFFFFF),
      pixel_vec(CMD_WRITE, 0, 256, 24'h000000),
      pixel_vec(CMD_WRITE, 4095, 4095, 24'hFFFFFF),
      pixel_vec(CMD_WRITE, 2048, 1, 24'h777777),
      pixel_vec(CMD_REQUEST, 0, 0, 24'h000000, 1'b1, 24'hFF00AA),
      pixel_vec(CMD_REQUEST, 254, 255, 24'h000000, 1'b1, 24'h000000),
      pixel_vec(CMD_REQUEST, 255, 254, 24'h000000, 1'b1, 24'h010203),
      pixel_vec(CMD_WRITE, 0, 0, 24'h000000),
      pixel_vec(CMD_REQUEST, 0, 0, 24'hFFFFFF, 1'b1, 24'h000000),
      pixel_vec(CMD_WRITE, 2, 0, 24'hABCDEF),
      pixel_vec(CMD_WRITE, 2, 1, 24'h0F0F0F),
      pixel_vec(CMD_REQUEST, 1, 0, 24'h000000, 1'b1, 24'h00FF55)
    };
    foreach (directed_tbl[i]) begin
      if (directed_tbl[i].beat.command == CMD_REQUEST)
        typed_pixel_q.push_back({directed_tbl[i].typed, directed_tbl[i].want});
      push_beat(directed_tbl[i].beat);
    end
    settle();

    phase_idx = 0;
    while (items_sent < ITEM_TARGET) begin
      case (phase_idx)
        0: load_regs('0, '1, '0, '1);
        1: load_regs(SIZE_W'(256), SIZE_W'(1), '1, '0);
        2: load_regs(SIZE_W'(2), SIZE_W'(2), 24'h008000, 24'h004000);
        3: load_regs(SIZE_W'(256), SIZE_W'(256), 24'h00C0DE, 24'h01ABCD);
        default: load_regs(pick_size(), pick_size(), pick_inv_scale(), pick_inv_scale());
      endcase
      pending = 1'b0;
      steps   = $urandom_range(20, 90);
      repeat (steps) begin
        roll = $urandom_range(0, 99);
        {beat.red_in, beat.green_in, beat.blue_in} = 24'($urandom);
        beat.command = CMD_WRITE;
        if (roll < 5) begin
          // write outside the store; the block drops it
          beat.column = COORD_W'($urandom_range(0, 4095));
          beat.row    = COORD_W'($urandom_range(0, 4095));
          if ($urandom_range(0, 1)) beat.column = COORD_W'($urandom_range(FRAME_W, 4095));
          else beat.row = COORD_W'($urandom_range(FRAME_H, 4095));
          push_beat(beat);
          items_sent++;
        end else if (roll < 10) begin
          beat.column = COORD_W'($urandom_range(0, FRAME_W - 1));
          beat.row    = COORD_W'($urandom_range(0, FRAME_H - 1));
          push_beat(beat);
          items_sent++;
        end else begin
          if (!pending) begin
            cand_col = pick_coord(gen_w, gen_xinv);
            cand_row = pick_coord(gen_h, gen_yinv);
            pending  = 1'b1;
          end
          map_axis(cand_col, gen_xinv, gen_w, x0, x1, wa);
          map_axis(cand_row, gen_yinv, gen_h, y0, y1, wb);
          nx   = '{x0, x1, x0, x1};
          ny   = '{y0, y0, y1, y1};
          slot = 4;
          for (int k = 3; k >= 0; k--)
            if (!pix_loaded[ny[k]][nx[k]]) slot = k;
          // overwrite a neighbor right before its read now and then
          if (slot == 4 && roll < 18) slot = $urandom_range(0, 3);
          if (slot < 4) begin
            beat.column = COORD_W'(nx[slot]);
            beat.row    = COORD_W'(ny[slot]);
          end else begin
            beat.command = CMD_REQUEST;
            beat.column  = cand_col;
            beat.row     = cand_row;
            pending      = 1'b0;
          end
          push_beat(beat);
          items_sent++;
        end
      end
      settle();
      phase_idx++;
    end

    if (err_cnt == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    #1_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
